/* sv/dshs_pkg.sv */
`default_nettype none
package dshs_pkg;

    // Grant queue depth; pending count is 3 bits wide
    localparam int GRANT_QUEUE_DEPTH = 4;

    localparam int PULSE_W  = 16;
    localparam int SETTLE_W = 20;
    localparam int HOLD_W   = 22;
    localparam int CFG_W    = 22;
    localparam int PEND_W   = 3;

    localparam logic [PULSE_W-1:0]  PULSE_RST  = 16'd1000;
    localparam logic [SETTLE_W-1:0] SETTLE_RST = 20'd5000;
    localparam logic [HOLD_W-1:0]   HOLD_RST   = 22'd300000;

    typedef enum logic [1:0] {
        CFG_PULSE  = 2'd0,
        CFG_SETTLE = 2'd1,
        CFG_HOLD   = 2'd2
    } t_cfg_idx;

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_PULSE  = 2'd1,
        PH_WAIT   = 2'd2,
        PH_SETTLE = 2'd3
    } t_phase;

    typedef enum logic [1:0] {
        REL_NONE    = 2'd0,
        REL_STABLE  = 2'd1,
        REL_TIMEOUT = 2'd2
    } t_release;

    typedef struct packed {
        logic grant;
        logic reed_closed;
    } t_tick;

    typedef struct packed {
        logic              relay_on;
        logic [1:0]        phase;
        logic [1:0]        release_kind;
        logic              grant_dropped;
        logic [PEND_W-1:0] pending_count;
    } t_result;

endpackage
`default_nettype wire

/* sv/dshs_tick_if.sv */
`default_nettype none
interface dshs_tick_if;
    logic valid;
    logic ready;
    logic grant;
    logic reed_closed;

    modport source (output valid, output grant, output reed_closed, input ready);
    modport sink   (input valid, input grant, input reed_closed, output ready);
endinterface
`default_nettype wire

/* sv/dshs_result_if.sv */
`default_nettype none
interface dshs_result_if;
    logic       valid;
    logic       ready;
    logic       relay_on;
    logic [1:0] phase;
    logic [1:0] release_kind;
    logic       grant_dropped;
    logic [2:0] pending_count;

    modport source (output valid, output relay_on, output phase, output release_kind,
                    output grant_dropped, output pending_count, input ready);
    modport sink   (input valid, input relay_on, input phase, input release_kind,
                    input grant_dropped, input pending_count, output ready);
endinterface
`default_nettype wire

/* sv/door_strike_hold_sequencer_top.sv */
// Door strike hold sequencer.
// i_tick carries one time tick per word: a grant pulse and the reed level.
// o_result returns one word per tick: relay drive, phase, release kind,
// dropped-grant flag and the number of grants still queued.
// Registers are written through i_cfg_we / i_cfg_idx / i_cfg_data:
// 0 pulse ticks, 1 settle ticks, 2 max hold ticks; index 3 is ignored.
// Write them only while no tick is in flight.
// A tick accepted into the queue register waits there until the sequencer steps
// it, and its result is then written into the result register.
// Throughput: one tick per cycle while the receiver takes results; the sequencer
// step (decrement, zero compare, phase select) is combinational.
// Reset clears the queue, the sequencer goes idle with no pending grants,
// and the registers return to 1000 / 5000 / 300000.
// When the receiver stalls, the result word holds, the two-entry input
// queue absorbs up to two more ticks, then i_tick.ready goes low.
`default_nettype none
module door_strike_hold_sequencer_top (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_cfg_we,
    input  wire [1:0]                  i_cfg_idx,
    input  wire [dshs_pkg::CFG_W-1:0]  i_cfg_data,
    dshs_tick_if.sink                  i_tick,
    dshs_result_if.source              o_result
);

    logic            deq_valid;
    logic            deq_ready;
    dshs_pkg::t_tick deq_word;

    dshs_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tick      (i_tick),
        .o_deq_valid (deq_valid),
        .o_deq_word  (deq_word),
        .i_deq_ready (deq_ready)
    );

    dshs_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_deq_valid (deq_valid),
        .i_deq_word  (deq_word),
        .o_deq_ready (deq_ready),
        .o_result    (o_result)
    );

endmodule
`default_nettype wire

/* sv/dshs_front.sv */
`default_nettype none
// Front: takes tick words and holds them in a two-entry queue
module dshs_front (
    input  wire            i_clk,
    input  wire            i_rst_n,
    dshs_tick_if.sink      i_tick,
    output logic           o_deq_valid,
    output dshs_pkg::t_tick o_deq_word,
    input  wire            i_deq_ready
);

    dshs_pkg::t_tick r_mem [2];
    logic            r_wr_ptr;
    logic            r_rd_ptr;
    logic [1:0]      r_count;
    logic [1:0]      n_count;
    logic            push;
    logic            pop;

    assign i_tick.ready = (r_count != 2'd2);
    assign push         = i_tick.valid && i_tick.ready;
    assign o_deq_valid  = (r_count != 2'd0);
    assign pop          = o_deq_valid && i_deq_ready;
    assign o_deq_word   = r_mem[r_rd_ptr];

    // occupancy
    always_comb begin
        n_count = r_count;
        case ({push, pop})
            2'b10:   n_count = r_count + 2'd1;
            2'b01:   n_count = r_count - 2'd1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_count <= n_count;
            if (push) r_wr_ptr <= ~r_wr_ptr;
            if (pop)  r_rd_ptr <= ~r_rd_ptr;
        end
    end

    // storage, classified into the tick struct
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr].grant       <= i_tick.grant;
            r_mem[r_wr_ptr].reed_closed <= i_tick.reed_closed;
        end
    end

endmodule
`default_nettype wire

/* sv/dshs_back.sv */
`default_nettype none
// Back: strike sequencer, one tick per cycle unless a result is held, registered result
module dshs_back (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_cfg_we,
    input  wire [1:0]                    i_cfg_idx,
    input  wire [dshs_pkg::CFG_W-1:0]    i_cfg_data,
    input  wire                          i_deq_valid,
    input  wire dshs_pkg::t_tick         i_deq_word,
    output logic                         o_deq_ready,
    dshs_result_if.source                o_result
);

    logic [dshs_pkg::PULSE_W-1:0]  r_pulse_ticks;
    logic [dshs_pkg::SETTLE_W-1:0] r_settle_ticks;
    logic [dshs_pkg::HOLD_W-1:0]   r_hold_ticks;

    dshs_pkg::t_phase              r_phase;
    dshs_pkg::t_phase              n_phase;
    logic [dshs_pkg::HOLD_W-1:0]   r_countdown;
    logic [dshs_pkg::HOLD_W-1:0]   n_countdown;
    logic [dshs_pkg::PEND_W-1:0]   r_pending;
    logic [dshs_pkg::PEND_W-1:0]   n_pending;
    dshs_pkg::t_release            n_release;
    logic                          n_dropped;

    logic                          r_out_valid;
    dshs_pkg::t_result             r_out;
    logic                          step;
    logic                          chk_pulse;
    logic                          chk_wait;
    logic                          chk_settle;
    logic                          closed;

    assign o_deq_ready = !r_out_valid || o_result.ready;
    assign step        = i_deq_valid && o_deq_ready;
    assign closed      = i_deq_word.reed_closed;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pulse_ticks  <= dshs_pkg::PULSE_RST;
            r_settle_ticks <= dshs_pkg::SETTLE_RST;
            r_hold_ticks   <= dshs_pkg::HOLD_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                dshs_pkg::CFG_PULSE:  r_pulse_ticks  <= i_cfg_data[dshs_pkg::PULSE_W-1:0];
                dshs_pkg::CFG_SETTLE: r_settle_ticks <= i_cfg_data[dshs_pkg::SETTLE_W-1:0];
                dshs_pkg::CFG_HOLD:   r_hold_ticks   <= i_cfg_data[dshs_pkg::HOLD_W-1:0];
                default: ;
            endcase
        end
    end

    // next state for one tick
    always_comb begin
        n_pending   = r_pending;
        n_dropped   = 1'b0;
        n_phase     = r_phase;
        n_countdown = r_countdown;
        n_release   = dshs_pkg::REL_NONE;
        chk_pulse   = 1'b0;
        chk_wait    = 1'b0;
        chk_settle  = 1'b0;

        // queue the grant first
        if (i_deq_word.grant) begin
            if (r_pending < dshs_pkg::PEND_W'(dshs_pkg::GRANT_QUEUE_DEPTH))
                n_pending = r_pending + 1'b1;
            else
                n_dropped = 1'b1;
        end

        unique case (r_phase)
            dshs_pkg::PH_IDLE: begin
                if (n_pending != '0) begin
                    n_pending   = n_pending - 1'b1;
                    n_phase     = dshs_pkg::PH_PULSE;
                    n_countdown = dshs_pkg::HOLD_W'(r_pulse_ticks);
                    chk_pulse   = 1'b1;
                end
            end
            dshs_pkg::PH_PULSE: begin
                if (r_countdown != '0) n_countdown = r_countdown - 1'b1;
                chk_pulse = 1'b1;
            end
            dshs_pkg::PH_WAIT: begin
                if (r_countdown != '0) n_countdown = r_countdown - 1'b1;
                chk_wait = 1'b1;
            end
            default: begin
                if (r_countdown != '0) n_countdown = r_countdown - 1'b1;
                chk_settle = 1'b1;
            end
        endcase

        // pulse done: start waiting for closure
        if (chk_pulse && n_countdown == '0) begin
            n_phase     = dshs_pkg::PH_WAIT;
            n_countdown = r_hold_ticks;
            chk_wait    = 1'b1;
        end

        // closure seen or timeout
        if (chk_wait) begin
            if (closed) begin
                n_phase     = dshs_pkg::PH_SETTLE;
                n_countdown = dshs_pkg::HOLD_W'(r_settle_ticks);
                chk_settle  = 1'b1;
            end else if (n_countdown == '0) begin
                n_release = dshs_pkg::REL_TIMEOUT;
                n_phase   = dshs_pkg::PH_IDLE;
            end
        end

        // settled close, or reopen back to waiting (timeout at once if hold is zero)
        if (chk_settle) begin
            if (n_countdown == '0) begin
                n_release = dshs_pkg::REL_STABLE;
                n_phase   = dshs_pkg::PH_IDLE;
            end else if (!closed) begin
                n_phase     = dshs_pkg::PH_WAIT;
                n_countdown = r_hold_ticks;
                if (r_hold_ticks == '0) begin
                    n_release = dshs_pkg::REL_TIMEOUT;
                    n_phase   = dshs_pkg::PH_IDLE;
                end
            end
        end
    end

    // sequencer state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= dshs_pkg::PH_IDLE;
            r_countdown <= '0;
            r_pending   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (step) begin
                r_phase     <= n_phase;
                r_countdown <= n_countdown;
                r_pending   <= n_pending;
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out.relay_on      <= (n_phase != dshs_pkg::PH_IDLE);
            r_out.phase         <= n_phase;
            r_out.release_kind  <= n_release;
            r_out.grant_dropped <= n_dropped;
            r_out.pending_count <= n_pending;
        end
    end

    assign o_result.valid         = r_out_valid;
    assign o_result.relay_on      = r_out.relay_on;
    assign o_result.phase         = r_out.phase;
    assign o_result.release_kind  = r_out.release_kind;
    assign o_result.grant_dropped = r_out.grant_dropped;
    assign o_result.pending_count = r_out.pending_count;

endmodule
`default_nettype wire

/* verif/door_strike_hold_sequencer_top_tb.sv */
`default_nettype none
module door_strike_hold_sequencer_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] CFG_UNUSED = 2'd3;   // no register behind this index
    localparam int STALL_LIMIT   = 2000;         // cycles with no word moving
    localparam int HOLDOFF_LEN   = 80;           // long receiver back-pressure
    localparam int SETTLE_CYCLES = 4;            // pipeline depth plus margin

    typedef enum int {
        FLOW_FREE,
        FLOW_SRC_GAPS,
        FLOW_SINK_STALLS,
        FLOW_BOTH
    } t_flow;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       cfg_we = 1'b0;
    logic [1:0]                 cfg_idx = dshs_pkg::CFG_PULSE;
    logic [dshs_pkg::CFG_W-1:0] cfg_data = '0;

    dshs_tick_if   tick_if();
    dshs_result_if rslt_if();

    door_strike_hold_sequencer_top uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_tick     (tick_if),
        .o_result   (rslt_if)
    );

    // clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // --- shadow of the sequencer ---
    logic [dshs_pkg::PULSE_W-1:0]  pulse_len  = dshs_pkg::PULSE_RST;
    logic [dshs_pkg::SETTLE_W-1:0] settle_len = dshs_pkg::SETTLE_RST;
    logic [dshs_pkg::HOLD_W-1:0]   hold_len   = dshs_pkg::HOLD_RST;
    dshs_pkg::t_phase              seq_phase  = dshs_pkg::PH_IDLE;
    logic [dshs_pkg::HOLD_W-1:0]   seq_count  = '0;
    int unsigned                   queued     = 0;
    dshs_pkg::t_release            rel_now    = dshs_pkg::REL_NONE;

    dshs_pkg::t_tick   tick_q[$];        // ticks waiting for the driver
    dshs_pkg::t_result strike_q[$];      // predicted result words, oldest first
    dshs_pkg::t_tick   offered;          // word currently on the tick channel
    t_flow   flow = FLOW_FREE;
    int      err_cnt = 0;
    int      n_ticks = 0, n_results = 0, n_stable = 0, n_timeout = 0, n_dropped = 0;
    int      holdoff_asked = 0, holdoff_seen = 0, holdoff_left = 0;
    int      quiet_cycles = 0;

    function automatic void settle_check(logic closed);
        if (seq_count == 0) begin
            rel_now   = dshs_pkg::REL_STABLE;
            seq_phase = dshs_pkg::PH_IDLE;
        end else if (!closed) begin
            // reopened: back to waiting with a fresh timeout
            seq_phase = dshs_pkg::PH_WAIT;
            seq_count = hold_len;
            if (seq_count == 0) begin
                rel_now   = dshs_pkg::REL_TIMEOUT;
                seq_phase = dshs_pkg::PH_IDLE;
            end
        end
    endfunction

    function automatic void closure_check(logic closed);
        if (closed) begin
            seq_phase = dshs_pkg::PH_SETTLE;
            seq_count = dshs_pkg::HOLD_W'(settle_len);
            settle_check(closed);
        end else if (seq_count == 0) begin
            rel_now   = dshs_pkg::REL_TIMEOUT;
            seq_phase = dshs_pkg::PH_IDLE;
        end
    endfunction

    function automatic void pulse_check(logic closed);
        if (seq_count == 0) begin
            seq_phase = dshs_pkg::PH_WAIT;
            seq_count = hold_len;
            closure_check(closed);
        end
    endfunction

    // one tick through the shadow sequencer
    function automatic dshs_pkg::t_result strike_step(dshs_pkg::t_tick w);
        dshs_pkg::t_result r;
        logic    dropped;
        dropped = 1'b0;
        if (w.grant) begin
            if (queued < dshs_pkg::GRANT_QUEUE_DEPTH) queued++;
            else dropped = 1'b1;
        end
        rel_now = dshs_pkg::REL_NONE;
        case (seq_phase)
            dshs_pkg::PH_IDLE: begin
                if (queued > 0) begin
                    queued--;
                    seq_phase = dshs_pkg::PH_PULSE;
                    seq_count = dshs_pkg::HOLD_W'(pulse_len);
                    pulse_check(w.reed_closed);
                end
            end
            dshs_pkg::PH_PULSE: begin
                if (seq_count != 0) seq_count--;
                pulse_check(w.reed_closed);
            end
            dshs_pkg::PH_WAIT: begin
                if (seq_count != 0) seq_count--;
                closure_check(w.reed_closed);
            end
            default: begin
                if (seq_count != 0) seq_count--;
                settle_check(w.reed_closed);
            end
        endcase
        r.relay_on      = (seq_phase != dshs_pkg::PH_IDLE);
        r.phase         = seq_phase;
        r.release_kind  = rel_now;
        r.grant_dropped = dropped;
        r.pending_count = dshs_pkg::PEND_W'(queued);
        if (rel_now == dshs_pkg::REL_STABLE) n_stable++;
        if (rel_now == dshs_pkg::REL_TIMEOUT) n_timeout++;
        if (dropped) n_dropped++;
        return r;
    endfunction

    function automatic bit sender_gap();
        case (flow)
            FLOW_SRC_GAPS: return $urandom_range(0, 99) < 59;
            FLOW_BOTH:     return $urandom_range(0, 99) < 38;
            default:       return 1'b0;
        endcase
    endfunction

    function automatic bit receiver_stall();
        case (flow)
            FLOW_SINK_STALLS: return $urandom_range(0, 99) < 59;
            FLOW_BOTH:        return $urandom_range(0, 99) < 38;
            default:          return 1'b0;
        endcase
    endfunction

    // tick driver
    always @(posedge i_clk) begin : tick_driver
        dshs_pkg::t_tick w;
        if (!i_rst_n) begin
            tick_if.valid <= 1'b0;
        end else begin
            if (tick_if.valid && tick_if.ready) begin
                strike_q.push_back(strike_step(offered));
                n_ticks++;
            end
            // hold the word while it is offered and not taken
            if (!(tick_if.valid && !tick_if.ready)) begin
                if (tick_q.size() > 0 && !sender_gap()) begin
                    w = tick_q.pop_front();
                    offered <= w;
                    tick_if.grant       <= w.grant;
                    tick_if.reed_closed <= w.reed_closed;
                    tick_if.valid       <= 1'b1;
                end else begin
                    tick_if.valid <= 1'b0;
                end
            end
        end
    end

    // result monitor and receiver back-pressure
    always @(posedge i_clk) begin : result_monitor
        dshs_pkg::t_result want;
        if (!i_rst_n) begin
            rslt_if.ready <= 1'b0;
        end else begin
            if (rslt_if.valid && rslt_if.ready) begin
                n_results++;
                if (strike_q.size() == 0) begin
                    $error("result word with no tick waiting for it");
                    err_cnt++;
                end else begin
                    want = strike_q.pop_front();
                    if (rslt_if.relay_on !== want.relay_on) begin
                        $error("relay_on: expected %0d, got %0d", want.relay_on, rslt_if.relay_on);
                        err_cnt++;
                    end
                    if (rslt_if.phase !== want.phase) begin
                        $error("phase: expected %0d, got %0d", want.phase, rslt_if.phase);
                        err_cnt++;
                    end
                    if (rslt_if.release_kind !== want.release_kind) begin
                        $error("release_kind: expected %0d, got %0d",
                               want.release_kind, rslt_if.release_kind);
                        err_cnt++;
                    end
                    if (rslt_if.grant_dropped !== want.grant_dropped) begin
                        $error("grant_dropped: expected %0d, got %0d",
                               want.grant_dropped, rslt_if.grant_dropped);
                        err_cnt++;
                    end
                    if (rslt_if.pending_count !== want.pending_count) begin
                        $error("pending_count: expected %0d, got %0d",
                               want.pending_count, rslt_if.pending_count);
                        err_cnt++;
                    end
                end
            end
            if (holdoff_seen != holdoff_asked) begin
                holdoff_seen = holdoff_asked;
                holdoff_left = HOLDOFF_LEN;
            end
            if (holdoff_left > 0) begin
                holdoff_left--;
                rslt_if.ready <= 1'b0;
            end else begin
                rslt_if.ready <= !receiver_stall();
            end
        end
    end

    // watchdog: no word moving on either side for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (tick_if.valid && tick_if.ready) || (rslt_if.valid && rslt_if.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("door_strike_hold_sequencer_top_tb: FAIL");
            $finish;
        end
    end

    task automatic write_reg(logic [1:0] idx, logic [dshs_pkg::CFG_W-1:0] data);
        @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        case (idx)
            dshs_pkg::CFG_PULSE:  pulse_len  = data[dshs_pkg::PULSE_W-1:0];
            dshs_pkg::CFG_SETTLE: settle_len = data[dshs_pkg::SETTLE_W-1:0];
            dshs_pkg::CFG_HOLD:   hold_len   = data[dshs_pkg::HOLD_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_timing(int p, int s, int h);
        write_reg(dshs_pkg::CFG_PULSE, dshs_pkg::CFG_W'(p));
        write_reg(dshs_pkg::CFG_SETTLE, dshs_pkg::CFG_W'(s));
        write_reg(dshs_pkg::CFG_HOLD, dshs_pkg::CFG_W'(h));
    endtask

    task automatic add_tick(logic g, logic r);
        dshs_pkg::t_tick w;
        w.grant       = g;
        w.reed_closed = r;
        tick_q.push_back(w);
    endtask

    // reed in runs of one level with the odd glitch; sparse grants, some bursts
    task automatic add_door_traffic(int n);
        int   left;
        int   run;
        logic reed;
        left = n;
        while (left > 0) begin
            if ($urandom_range(0, 19) == 0) begin
                for (int k = 0; k < 6 && left > 0; k++) begin
                    add_tick(1'b1, 1'($urandom_range(0, 1)));
                    left--;
                end
            end
            reed = 1'($urandom_range(0, 1));
            run  = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 20) : $urandom_range(1, 6);
            for (int k = 0; k < run && left > 0; k++) begin
                add_tick($urandom_range(0, 11) == 0,
                         ($urandom_range(0, 15) == 0) ? !reed : reed);
                left--;
            end
        end
    endtask

    // let every queued tick through and every result back
    task automatic drain();
        while (tick_q.size() != 0 || strike_q.size() != 0 || tick_if.valid)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        tick_if.valid       = 1'b0;
        tick_if.grant       = 1'b0;
        tick_if.reed_closed = 1'b0;
        rslt_if.ready       = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset timing: fill the grant queue until one is dropped
        repeat (6) add_tick(1'b1, 1'b0);
        add_tick(1'b0, 1'b1);
        add_tick(1'b0, 1'b0);
        drain();

        // shorten everything mid-pulse; new values only apply on the next load
        set_timing(0, 0, 0);
        write_reg(CFG_UNUSED, '1);
        add_door_traffic(1000);
        drain();

        // zero durations: stable release and timeout in the grant tick
        add_tick(1'b1, 1'b1);
        add_tick(1'b0, 1'b0);
        add_tick(1'b1, 1'b0);
        add_tick(1'b0, 1'b1);
        drain();

        // short timing: timeout, then reopen during settle, then stable
        set_timing(2, 3, 4);
        add_tick(1'b1, 1'b0);
        repeat (7) add_tick(1'b0, 1'b0);
        add_tick(1'b0, 1'b1);
        add_tick(1'b1, 1'b1);
        repeat (3) add_tick(1'b0, 1'b1);
        add_tick(1'b0, 1'b0);
        repeat (5) add_tick(1'b0, 1'b1);
        drain();

        // long back-pressure while ticks keep coming
        add_door_traffic(40);
        holdoff_asked++;
        drain();

        // random timing, every flow mode twice
        for (int ph = 0; ph < 8; ph++) begin
            set_timing($urandom_range(0, 6), $urandom_range(0, 6), $urandom_range(0, 8));
            flow = t_flow'(ph % 4);
            add_door_traffic(12);
            drain();
        end
        flow = FLOW_FREE;

        // pulse written with the upper data bits set, widest hold left by a close
        write_reg(dshs_pkg::CFG_PULSE, dshs_pkg::CFG_W'(22'h3F_0010));
        write_reg(dshs_pkg::CFG_SETTLE, dshs_pkg::CFG_W'(2));
        write_reg(dshs_pkg::CFG_HOLD, '1);
        add_tick(1'b1, 1'b0);
        repeat (24) add_tick(1'b0, 1'b0);
        repeat (8) add_tick(1'b0, 1'b1);
        drain();

        // widest settle, left by a reopen into a zero hold
        write_reg(dshs_pkg::CFG_PULSE, '0);
        write_reg(dshs_pkg::CFG_SETTLE, '1);
        write_reg(dshs_pkg::CFG_HOLD, '0);
        add_tick(1'b1, 1'b1);
        repeat (10) add_tick(1'b0, 1'b1);
        repeat (2) add_tick(1'b0, 1'b0);
        drain();

        if (strike_q.size() != 0) begin
            $error("%0d result words never arrived", strike_q.size());
            err_cnt++;
        end
        $display("Ran %0d ticks and checked %0d result words over reset, zero, short,",
                 n_ticks, n_results);
        $display("random and wide timings: %0d stable, %0d timeout releases, %0d grants dropped",
                 n_stable, n_timeout, n_dropped);
        if (err_cnt == 0) begin
            $display("door_strike_hold_sequencer_top_tb: PASS");
        end else begin
            $display("door_strike_hold_sequencer_top_tb: FAIL");
        end
        $finish;
    end

endmodule
`default_nettype wire
